// ----- src/salsa_pkg.sv -----
// Shared types and constants for the Salsa20/20 stream cipher block.
package salsa_pkg;

    // Datapath operations issued by the microcode sequencer
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;  // build input state into working words
    localparam logic [2:0] OP_QCOL  = 3'd2;  // column quarter-round, then diagonal shift
    localparam logic [2:0] OP_QROW  = 3'd3;  // row quarter-round, then diagonal shift
    localparam logic [2:0] OP_FINAL = 3'd4;  // add input state, words become keystream

    // Salsa20 "expand 32-byte k" constants
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646E;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2D32;
    localparam logic [31:0] SIGMA_3 = 32'h6B20_6574;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY_01 = 3'd0;
    localparam logic [2:0] REG_KEY_23 = 3'd1;
    localparam logic [2:0] REG_KEY_45 = 3'd2;
    localparam logic [2:0] REG_KEY_67 = 3'd3;
    localparam logic [2:0] REG_NONCE  = 3'd4;

    // Per-cycle control from sequencer to datapath
    typedef struct packed {
        logic [2:0] op;
        logic       done;   // last step of the block program
    } t_dp_ctl;

    typedef logic [7:0][31:0] t_key;

endpackage

// ----- src/salsa_useq.sv -----
// Microcode sequencer: step counter, loop counter and the control ROM.
module salsa_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output salsa_pkg::t_dp_ctl  o_ctl
);

    // One control word per step
    typedef struct packed {
        logic [2:0] op;
        logic       loop_set;
        logic       loop_jump;
        logic       last;
        logic [3:0] target;
    } t_uword;

    localparam logic [3:0] LOOP_COUNT = 4'd10;   // ten double rounds
    localparam logic [3:0] LOOP_TOP   = 4'd1;

    function automatic t_uword rom_word(input logic [3:0] pc);
        t_uword w;
        w = '{op: salsa_pkg::OP_NOP, loop_set: 1'b0, loop_jump: 1'b0,
              last: 1'b0, target: 4'd0};
        case (pc)
            4'd0: begin
                w.op       = salsa_pkg::OP_LOAD;
                w.loop_set = 1'b1;
            end
            4'd1, 4'd2, 4'd3, 4'd4: begin
                w.op = salsa_pkg::OP_QCOL;
            end
            4'd5, 4'd6, 4'd7: begin
                w.op = salsa_pkg::OP_QROW;
            end
            4'd8: begin
                w.op        = salsa_pkg::OP_QROW;
                w.loop_jump = 1'b1;
                w.target    = LOOP_TOP;
            end
            4'd9: begin
                w.op   = salsa_pkg::OP_FINAL;
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    logic       r_busy;
    logic [3:0] r_pc;
    logic [3:0] r_loop;
    t_uword     w_cur;

    assign w_cur = rom_word(r_pc);

    // Step counter with conditional jump back to the loop top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= 4'd0;
            r_loop <= 4'd0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= 4'd0;
            end
        end else begin
            if (w_cur.loop_set) begin
                r_loop <= LOOP_COUNT;
            end
            if (w_cur.last) begin
                r_busy <= 1'b0;
            end else if (w_cur.loop_jump && (r_loop != 4'd1)) begin
                r_pc   <= w_cur.target;
                r_loop <= r_loop - 4'd1;
            end else begin
                r_pc <= r_pc + 4'd1;
            end
        end
    end

    assign o_ctl.op   = r_busy ? w_cur.op : salsa_pkg::OP_NOP;
    assign o_ctl.done = r_busy & w_cur.last;

endmodule

// ----- src/salsa_core.sv -----
// Salsa20 datapath: 16 working words, one quarter-round unit, final add.
module salsa_core (
    input  logic                i_clk,
    input  salsa_pkg::t_dp_ctl  i_ctl,
    input  salsa_pkg::t_key     i_key,
    input  logic [63:0]         i_nonce,
    input  logic [63:0]         i_counter,
    input  logic [3:0]          i_rd_idx,
    output logic [31:0]         o_ks_word
);

    logic [31:0] r_work [16];
    logic [31:0] n_work [16];
    logic [31:0] w_init [16];
    logic [31:0] w_qr   [16];
    logic [31:0] w_shft [16];
    logic [31:0] q_a, q_b, q_c, q_d;
    logic [31:0] b1, c1, d1, a1;
    logic [31:0] s_ad, s_ba, s_cb, s_dc;
    logic        row_mode;

    // Input state: constants on the diagonal, key, nonce and counter
    always_comb begin
        w_init[0]  = salsa_pkg::SIGMA_0;
        w_init[1]  = i_key[0];
        w_init[2]  = i_key[1];
        w_init[3]  = i_key[2];
        w_init[4]  = i_key[3];
        w_init[5]  = salsa_pkg::SIGMA_1;
        w_init[6]  = i_nonce[31:0];
        w_init[7]  = i_nonce[63:32];
        w_init[8]  = i_counter[31:0];
        w_init[9]  = i_counter[63:32];
        w_init[10] = salsa_pkg::SIGMA_2;
        w_init[11] = i_key[4];
        w_init[12] = i_key[5];
        w_init[13] = i_key[6];
        w_init[14] = i_key[7];
        w_init[15] = salsa_pkg::SIGMA_3;
    end

    // Quarter-round on column 0 (words 0,4,8,12) or row 0 (words 0,1,2,3)
    assign row_mode = (i_ctl.op == salsa_pkg::OP_QROW);
    assign q_a = r_work[0];
    assign q_b = row_mode ? r_work[1] : r_work[4];
    assign q_c = row_mode ? r_work[2] : r_work[8];
    assign q_d = row_mode ? r_work[3] : r_work[12];

    assign s_ad = q_a + q_d;
    assign b1   = q_b ^ {s_ad[24:0], s_ad[31:25]};
    assign s_ba = b1 + q_a;
    assign c1   = q_c ^ {s_ba[22:0], s_ba[31:23]};
    assign s_cb = c1 + b1;
    assign d1   = q_d ^ {s_cb[18:0], s_cb[31:19]};
    assign s_dc = d1 + c1;
    assign a1   = q_a ^ {s_dc[13:0], s_dc[31:14]};

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_qr[i] = r_work[i];
        end
        w_qr[0] = a1;
        if (row_mode) begin
            w_qr[1] = b1;
            w_qr[2] = c1;
            w_qr[3] = d1;
        end else begin
            w_qr[4]  = b1;
            w_qr[8]  = c1;
            w_qr[12] = d1;
        end
    end

    // Diagonal shift: the next quarter-round's words move to fixed places
    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign w_shft[4*r + c] = w_qr[4*((r + 1) % 4) + ((c + 1) % 4)];
        end
    end

    // Next value of the working words per operation
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            case (i_ctl.op)
                salsa_pkg::OP_LOAD:  n_work[i] = w_init[i];
                salsa_pkg::OP_QCOL,
                salsa_pkg::OP_QROW:  n_work[i] = w_shft[i];
                salsa_pkg::OP_FINAL: n_work[i] = r_work[i] + w_init[i];
                default:             n_work[i] = r_work[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            r_work[i] <= n_work[i];
        end
    end

    assign o_ks_word = r_work[i_rd_idx];

endmodule

// ----- src/salsa20_stream_cipher_top.sv -----
// Salsa20/20 stream cipher top level: config registers, item flow, output register.
//
// Usage: write the key (registers 0..3) and the nonce (register 4) on the
// config port while the block is idle; each write restarts the keystream at
// block counter zero. Message words enter on the input channel (valid/ready)
// with a byte count and an end-of-message flag; each returns one item on the
// output channel with the word XORed with keystream and unused lanes zeroed.
// A word that opens a 64-byte block waits for the block computation,
// 82 sequencer steps (state load, 80 quarter-rounds, final add), then passes
// through the XOR state and the output register before it reaches the output.
// The other words of the block come out in the cycle after acceptance, one
// per cycle while the receiver does not stall. The quarter-round unit does
// one quarter-round per cycle.
// An end-of-message word drops the rest of the block; the next word starts
// a new block with the incremented counter.
// Reset clears the config registers, counter and position; no block is held.
// A stalled receiver holds the output register; a new item is taken only
// when the output register is free or being emptied in the same cycle.
module salsa20_stream_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_in,
    input  logic [2:0]  i_byte_count,
    input  logic        i_message_end,
    // output item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_data_out,
    output logic [2:0]  o_out_bytes,
    output logic        o_out_end
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_XOR  = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [63:0] r_key [4];
    logic [63:0] r_nonce;
    logic [63:0] r_block_cnt;
    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic        r_ks_ready;
    logic [31:0] r_hold_data;
    logic [2:0]  r_hold_count;
    logic        r_hold_end;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [2:0]  r_out_bytes;
    logic        r_out_end;

    logic               in_acc;
    logic               out_load;
    logic               seq_start;
    salsa_pkg::t_dp_ctl dp_ctl;
    salsa_pkg::t_key    key_words;
    logic [31:0]        ks_word;
    logic [31:0]        sel_data;
    logic [2:0]         sel_count;
    logic               sel_end;
    logic [2:0]         clamp_count;
    logic [31:0]        lane_mask;

    // Handshake
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign seq_start  = in_acc && !r_ks_ready;
    assign out_load   = (in_acc && r_ks_ready) || (r_state == ST_XOR);

    // Key words in state order
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            key_words[2*i]     = r_key[i][31:0];
            key_words[2*i + 1] = r_key[i][63:32];
        end
    end

    salsa_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seq_start),
        .o_ctl   (dp_ctl)
    );

    salsa_core u_core (
        .i_clk     (i_clk),
        .i_ctl     (dp_ctl),
        .i_key     (key_words),
        .i_nonce   (r_nonce),
        .i_counter (r_block_cnt),
        .i_rd_idx  (r_pos),
        .o_ks_word (ks_word)
    );

    // Item source: straight from the port, or the word held during a block compute
    assign sel_data  = (r_state == ST_XOR) ? r_hold_data  : i_data_in;
    assign sel_count = (r_state == ST_XOR) ? r_hold_count : i_byte_count;
    assign sel_end   = (r_state == ST_XOR) ? r_hold_end   : i_message_end;

    assign clamp_count = (sel_count > 3'd4) ? 3'd4 : sel_count;

    always_comb begin
        case (clamp_count)
            3'd0:    lane_mask = 32'h0000_0000;
            3'd1:    lane_mask = 32'h0000_00FF;
            3'd2:    lane_mask = 32'h0000_FFFF;
            3'd3:    lane_mask = 32'h00FF_FFFF;
            default: lane_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign n_pos = r_pos + 4'd1;

    // Control flow
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (seq_start)   n_state = ST_CALC;
            ST_CALC: if (dp_ctl.done) n_state = ST_XOR;
            ST_XOR:                   n_state = ST_IDLE;
            default:                  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_block_cnt <= 64'd0;
            r_pos       <= 4'd0;
            r_ks_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_nonce     <= 64'd0;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= 64'd0;
            end
        end else begin
            r_state <= n_state;

            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // key and nonce writes restart the keystream; else block done or word used
            if (i_cfg_wr_en && (i_cfg_index <= salsa_pkg::REG_NONCE)) begin
                r_block_cnt <= 64'd0;
                r_pos       <= 4'd0;
                r_ks_ready  <= 1'b0;
            end else if (dp_ctl.done) begin
                r_block_cnt <= r_block_cnt + 64'd1;
                r_ks_ready  <= 1'b1;
                r_pos       <= 4'd0;
            end else if (out_load) begin
                if ((n_pos == 4'd0) || sel_end) begin
                    r_pos      <= 4'd0;
                    r_ks_ready <= 1'b0;
                end else begin
                    r_pos <= n_pos;
                end
            end

            // config register contents
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    salsa_pkg::REG_KEY_01: r_key[0] <= i_cfg_data;
                    salsa_pkg::REG_KEY_23: r_key[1] <= i_cfg_data;
                    salsa_pkg::REG_KEY_45: r_key[2] <= i_cfg_data;
                    salsa_pkg::REG_KEY_67: r_key[3] <= i_cfg_data;
                    salsa_pkg::REG_NONCE:  r_nonce  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hold_data  <= i_data_in;
            r_hold_count <= i_byte_count;
            r_hold_end   <= i_message_end;
        end
        if (out_load) begin
            r_out_data  <= (sel_data ^ ks_word) & lane_mask;
            r_out_bytes <= clamp_count;
            r_out_end   <= sel_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_out_bytes = r_out_bytes;
    assign o_out_end   = r_out_end;

endmodule
